@@ rtl/core/i2cmbe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared constants for the I2C master bit engine: command codes, byte length
// and the reset value of the bus-reset hold register.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    typedef logic [2:0] t_cmd;

    localparam t_cmd CMD_START    = 3'd0;
    localparam t_cmd CMD_STOP     = 3'd1;
    localparam t_cmd CMD_WRITE    = 3'd2;
    localparam t_cmd CMD_READ     = 3'd3;
    localparam t_cmd CMD_BUSRESET = 3'd4;

    localparam int          BYTE_BITS  = 8;
    localparam logic [7:0]  BIT_COUNT  = 8'(BYTE_BITS);
    localparam logic [7:0]  HOLD_RESET = 8'd200;

endpackage
`default_nettype wire

@@ rtl/core/i2c_master_bit_engine_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master pin sequencer, advanced one quarter-bit phase per input
// transaction. Runs start, stop, write byte, read byte and bus reset.
//
//   channel  direction  handshake                payload
//   in       to block   i_in_valid / o_in_stall  cmd_valid, req_type, tx_byte,
//                                                send_ack, sda_in
//   out      from block o_out_valid / i_out_stall scl_out, sda_out,
//                                                sda_released, busy_res,
//                                                done_res, rx_byte, ack_ok
//   cfg      to block   i_cfg_we                 i_cfg_wdata (reset hold ticks)
//
// One transaction per cycle unless stalled; its result is registered.
// The sequencer state and the result register update in the same clock edge.
// The input stalls only while a result waits and the output is stalled.
// Synchronous active-low reset: SCL and SDA idle high, no result pending.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic       i_cmd_valid,
    input  wire logic [2:0] i_req_type,
    input  wire logic [7:0] i_tx_byte,
    input  wire logic       i_send_ack,
    input  wire logic       i_sda_in,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_scl_out,
    output logic            o_sda_out,
    output logic            o_sda_released,
    output logic            o_busy_res,
    output logic            o_done_res,
    output logic [7:0]      o_rx_byte,
    output logic            o_ack_ok
);

    logic [7:0]       r_hold_ticks;
    i2cmbe_pkg::t_cmd r_cmd,        n_cmd;
    logic             r_busy,       n_busy;
    logic [2:0]       r_step,       n_step;
    logic [7:0]       r_hold,       n_hold;
    logic [7:0]       r_shift,      n_shift;
    logic             r_scl,        n_scl;
    logic             r_sda,        n_sda;
    logic             r_ack_flag,   n_ack_flag;
    logic             r_ack_choice, n_ack_choice;
    logic             r_sda_free,   n_sda_free;
    logic [7:0]       r_rx,         n_rx;
    logic             r_ran,        n_ran;
    logic             r_fin,        n_fin;
    logic             r_out_valid;

    logic             in_take;
    logic [7:0]       hold_len;

    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;
    assign hold_len   = (r_hold_ticks == 8'd0) ? 8'd1 : r_hold_ticks;

    always_comb begin
        logic       step_inc;
        logic [7:0] hold_dec;
        n_cmd        = r_cmd;
        n_busy       = r_busy;
        n_step       = r_step;
        n_hold       = r_hold;
        n_shift      = r_shift;
        n_scl        = r_scl;
        n_sda        = r_sda;
        n_ack_flag   = r_ack_flag;
        n_ack_choice = r_ack_choice;
        n_sda_free   = r_sda_free;
        n_rx         = r_rx;
        n_ran        = 1'b0;
        n_fin        = 1'b0;
        step_inc     = 1'b1;
        hold_dec     = 8'd0;

        if (!r_busy && i_cmd_valid && i_req_type <= i2cmbe_pkg::CMD_BUSRESET) begin
            n_cmd  = i_req_type;
            n_busy = 1'b1;
            n_step = 3'd0;
            if (i_req_type == i2cmbe_pkg::CMD_WRITE) n_shift = i_tx_byte;
            if (i_req_type == i2cmbe_pkg::CMD_READ) n_ack_choice = i_send_ack;
            if (i_req_type == i2cmbe_pkg::CMD_BUSRESET) n_hold = hold_len;
        end

        if (n_busy) begin
            n_ran    = 1'b1;
            hold_dec = n_hold - 8'd1;
            case (n_cmd)
                i2cmbe_pkg::CMD_START: begin
                    case (n_step)
                        3'd0: begin n_sda_free = 1'b0; n_sda = 1'b1; end
                        3'd1: n_scl = 1'b1;
                        3'd2: begin n_sda_free = 1'b0; n_sda = 1'b0; end
                        default: begin n_scl = 1'b0; n_fin = 1'b1; end
                    endcase
                end
                i2cmbe_pkg::CMD_STOP: begin
                    case (n_step)
                        3'd0: begin n_sda_free = 1'b0; n_sda = 1'b0; end
                        3'd1: n_scl = 1'b1;
                        default: begin
                            n_sda_free = 1'b0;
                            n_sda      = 1'b1;
                            n_fin      = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::CMD_BUSRESET: begin
                    step_inc   = 1'b0;
                    n_scl      = 1'b0;
                    n_sda_free = 1'b0;
                    n_sda      = (n_step != 3'd0);
                    n_hold     = hold_dec;
                    if (hold_dec == 8'd0) begin
                        if (n_step == 3'd0) begin
                            n_step = 3'd1;
                            n_hold = hold_len;
                        end else begin
                            n_fin = 1'b1;
                        end
                    end
                end
                i2cmbe_pkg::CMD_WRITE: begin
                    case (n_step)
                        3'd0: begin
                            n_sda_free = 1'b0;
                            n_scl      = 1'b0;
                            n_hold     = i2cmbe_pkg::BIT_COUNT;
                        end
                        3'd1: begin n_sda_free = 1'b0; n_sda = n_shift[7]; end
                        3'd2: n_scl = 1'b0;
                        3'd3: n_scl = 1'b1;
                        3'd4: begin
                            step_inc = 1'b0;
                            n_scl    = 1'b0;
                            n_shift  = {n_shift[6:0], 1'b0};
                            n_hold   = hold_dec;
                            n_step   = (hold_dec != 8'd0) ? 3'd1 : 3'd5;
                        end
                        3'd5: begin n_sda_free = 1'b1; n_sda = 1'b1; n_scl = 1'b0; end
                        3'd6: n_scl = 1'b1;
                        default: begin
                            n_ack_flag = ~i_sda_in;
                            n_scl      = 1'b0;
                            n_fin      = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::CMD_READ: begin
                    case (n_step)
                        3'd0: begin
                            n_sda_free = 1'b1;
                            n_sda      = 1'b1;
                            n_scl      = 1'b0;
                            n_shift    = 8'd0;
                            n_hold     = i2cmbe_pkg::BIT_COUNT;
                        end
                        3'd1: begin n_shift = {n_shift[6:0], 1'b0}; n_scl = 1'b1; end
                        3'd2: begin
                            step_inc = 1'b0;
                            n_shift  = {n_shift[7:1], n_shift[0] | i_sda_in};
                            n_scl    = 1'b0;
                            n_hold   = hold_dec;
                            n_step   = (hold_dec != 8'd0) ? 3'd1 : 3'd3;
                        end
                        3'd3: begin n_sda_free = 1'b0; n_sda = ~n_ack_choice; end
                        3'd4: n_scl = 1'b1;
                        default: begin n_scl = 1'b0; n_rx = n_shift; n_fin = 1'b1; end
                    endcase
                end
                default: n_fin = 1'b1;
            endcase
            if (step_inc) n_step = n_step + 3'd1;
            if (n_fin) begin
                n_busy = 1'b0;
                n_step = 3'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_ticks <= i2cmbe_pkg::HOLD_RESET;
        end else if (i_cfg_we) begin
            r_hold_ticks <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd        <= i2cmbe_pkg::CMD_START;
            r_busy       <= 1'b0;
            r_step       <= 3'd0;
            r_hold       <= 8'd0;
            r_shift      <= 8'd0;
            r_scl        <= 1'b1;
            r_sda        <= 1'b1;
            r_ack_flag   <= 1'b0;
            r_ack_choice <= 1'b0;
            r_sda_free   <= 1'b0;
            r_rx         <= 8'd0;
            r_ran        <= 1'b0;
            r_fin        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_cmd        <= n_cmd;
                r_busy       <= n_busy;
                r_step       <= n_step;
                r_hold       <= n_hold;
                r_shift      <= n_shift;
                r_scl        <= n_scl;
                r_sda        <= n_sda;
                r_ack_flag   <= n_ack_flag;
                r_ack_choice <= n_ack_choice;
                r_sda_free   <= n_sda_free;
                r_rx         <= n_rx;
                r_ran        <= n_ran;
                r_fin        <= n_fin;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scl_out      = r_scl;
    assign o_sda_out      = r_sda;
    assign o_sda_released = r_sda_free;
    assign o_busy_res     = r_ran;
    assign o_done_res     = r_fin;
    assign o_rx_byte      = r_rx;
    assign o_ack_ok       = r_ack_flag;

endmodule
`default_nettype wire

@@ rtl/core/i2cmbe_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// i2cmbe_checker
// Port-level checks for the I2C master bit engine, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmbe_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic       o_scl_out,
    input wire logic       o_sda_out,
    input wire logic       o_sda_released,
    input wire logic       o_busy_res,
    input wire logic       o_done_res,
    input wire logic [7:0] o_rx_byte
);

    a_done_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> o_busy_res)
        else $error("done without busy");

    a_released_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sda_released |-> o_sda_out)
        else $error("released SDA not reported high");

    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted transaction gave no result");

    a_stalled_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_scl_out)
            && $stable(o_sda_out) && $stable(o_rx_byte) && $stable(o_done_res))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_unit i2cmbe_checker u_i2cmbe_checker (.*);
`default_nettype wire

@@ test/tb_i2c_master_bit_engine_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_i2c_master_bit_engine_unit
// Self-checking bench for the I2C master bit engine. Every tick transaction
// runs through a cycle-level model of the pin sequencer, and each result
// transaction is compared field by field with the oldest prediction. A short
// directed table comes first. Random I2C traffic follows over several
// bus-reset hold settings, with random gaps on the input and random output
// stalls in every setting but the second.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_engine_unit;

    localparam int               RAND_TICKS     = 300;
    localparam int               PHASES         = 6;
    localparam int               WATCHDOG_LIMIT = 2000;
    localparam int               TAIL_CYCLES    = 4;
    localparam int               DIR_ROWS       = 16;
    localparam i2cmbe_pkg::t_cmd REQ_RSVD_5     = 3'd5;
    localparam i2cmbe_pkg::t_cmd REQ_RSVD_6     = 3'd6;
    localparam i2cmbe_pkg::t_cmd REQ_RSVD_7     = 3'd7;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       sda_rel;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } t_pins;

    typedef struct packed {
        logic             cv;
        i2cmbe_pkg::t_cmd req;
        logic [7:0]       tx;
        logic             sack;
        logic [7:0]       sda_pat;
        logic             noise;
        logic             has_exp;
        t_pins            exp;
    } t_dir_row;

    localparam t_pins NO_PINS    = '0;
    localparam t_pins RESET_PINS = '{scl: 1'b1, sda: 1'b1, sda_rel: 1'b0, busy: 1'b0,
                                     done: 1'b0, rx: 8'h00, ack: 1'b0};

    t_dir_row dir_rows [DIR_ROWS] = '{
        '{1'b0, i2cmbe_pkg::CMD_START,    8'h00, 1'b0, 8'h00, 1'b0, 1'b1, RESET_PINS},
        '{1'b1, REQ_RSVD_5,               8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, RESET_PINS},
        '{1'b1, REQ_RSVD_6,               8'h00, 1'b0, 8'h00, 1'b0, 1'b1, RESET_PINS},
        '{1'b1, REQ_RSVD_7,               8'hFF, 1'b1, 8'hFF, 1'b0, 1'b1, RESET_PINS},
        '{1'b1, i2cmbe_pkg::CMD_BUSRESET, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_START,    8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_WRITE,    8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_WRITE,    8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_WRITE,    8'hA5, 1'b0, 8'h0F, 1'b1, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_READ,     8'h00, 1'b1, 8'hFF, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_READ,     8'hFF, 1'b0, 8'h00, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_READ,     8'h3C, 1'b1, 8'h5A, 1'b1, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_START,    8'h00, 1'b0, 8'hF0, 1'b0, 1'b0, NO_PINS},
        '{1'b1, i2cmbe_pkg::CMD_STOP,     8'hFF, 1'b1, 8'h00, 1'b1, 1'b0, NO_PINS},
        '{1'b1, REQ_RSVD_7,               8'h00, 1'b0, 8'hFF, 1'b0, 1'b0, NO_PINS},
        '{1'b0, i2cmbe_pkg::CMD_BUSRESET, 8'hFF, 1'b1, 8'hFF, 1'b0, 1'b0, NO_PINS}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'h00;
    logic       in_valid  = 1'b0;
    logic       cmd_valid = 1'b0;
    logic [2:0] req_type  = i2cmbe_pkg::CMD_START;
    logic [7:0] tx_byte   = 8'h00;
    logic       send_ack  = 1'b0;
    logic       sda_in    = 1'b1;
    logic       out_stall = 1'b0;
    logic       in_stall;
    logic       out_valid;
    logic       scl_out;
    logic       sda_out;
    logic       sda_released;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;

    bit send_gaps  = 1'b1;
    bit stall_gaps = 1'b1;

    int error_count  = 0;
    int result_count = 0;
    int engine_ticks = 0;
    int cmd_count    = 0;
    int quiet        = 0;

    t_pins pins_due [$];

    // predictor state
    logic [7:0]       hold_ticks;
    i2cmbe_pkg::t_cmd eng_cmd;
    bit               eng_busy;
    logic [5:0]       eng_step;
    logic [7:0]       eng_hold;
    logic [7:0]       eng_shift;
    bit               eng_scl;
    bit               eng_sda;
    bit               eng_free;
    bit               eng_ack;
    bit               eng_ack_sel;
    logic [7:0]       eng_rx;

    i2c_master_bit_engine_unit dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_cmd_valid    (cmd_valid),
        .i_req_type     (req_type),
        .i_tx_byte      (tx_byte),
        .i_send_ack     (send_ack),
        .i_sda_in       (sda_in),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_scl_out      (scl_out),
        .o_sda_out      (sda_out),
        .o_sda_released (sda_released),
        .o_busy_res     (busy_res),
        .o_done_res     (done_res),
        .o_rx_byte      (rx_byte),
        .o_ack_ok       (ack_ok)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] hold_span();
        return (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
    endfunction

    function automatic void drive_sda(input bit level);
        eng_free = 1'b0;
        eng_sda  = level;
    endfunction

    function automatic void free_sda();
        eng_free = 1'b1;
        eng_sda  = 1'b1;
    endfunction

    function automatic t_pins bus_tick(input bit cv, input i2cmbe_pkg::t_cmd req,
                                       input logic [7:0] tx, input bit sack,
                                       input bit sda);
        t_pins r;
        bit    fin;
        bit    adv;
        fin    = 1'b0;
        adv    = 1'b1;
        r.busy = 1'b0;
        if (!eng_busy && cv && req <= i2cmbe_pkg::CMD_BUSRESET) begin
            eng_cmd  = req;
            eng_busy = 1'b1;
            eng_step = '0;
            if (req == i2cmbe_pkg::CMD_WRITE) eng_shift = tx;
            if (req == i2cmbe_pkg::CMD_READ) eng_ack_sel = sack;
            if (req == i2cmbe_pkg::CMD_BUSRESET) eng_hold = hold_span();
            cmd_count++;
        end
        if (eng_busy) begin
            r.busy = 1'b1;
            case (eng_cmd)
                i2cmbe_pkg::CMD_START: begin
                    case (eng_step)
                        6'd0: drive_sda(1'b1);
                        6'd1: eng_scl = 1'b1;
                        6'd2: drive_sda(1'b0);
                        default: begin
                            eng_scl = 1'b0;
                            fin     = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::CMD_STOP: begin
                    case (eng_step)
                        6'd0: drive_sda(1'b0);
                        6'd1: eng_scl = 1'b1;
                        default: begin
                            drive_sda(1'b1);
                            fin = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::CMD_BUSRESET: begin
                    eng_scl = 1'b0;
                    drive_sda(eng_step != 6'd0);
                    eng_hold = eng_hold - 8'd1;
                    if (eng_hold == 8'd0) begin
                        if (eng_step == 6'd0) begin
                            eng_step = 6'd1;
                            eng_hold = hold_span();
                        end else begin
                            fin = 1'b1;
                        end
                    end
                    adv = 1'b0;
                end
                i2cmbe_pkg::CMD_WRITE: begin
                    case (eng_step)
                        6'd0: begin
                            drive_sda(eng_sda);
                            eng_scl  = 1'b0;
                            eng_hold = i2cmbe_pkg::BIT_COUNT;
                        end
                        6'd1: drive_sda(eng_shift[7]);
                        6'd2: eng_scl = 1'b0;
                        6'd3: eng_scl = 1'b1;
                        6'd4: begin
                            eng_scl   = 1'b0;
                            eng_shift = eng_shift << 1;
                            eng_hold  = eng_hold - 8'd1;
                            eng_step  = (eng_hold != 8'd0) ? 6'd1 : 6'd5;
                            adv       = 1'b0;
                        end
                        6'd5: begin
                            free_sda();
                            eng_scl = 1'b0;
                        end
                        6'd6: eng_scl = 1'b1;
                        default: begin
                            eng_ack = !sda;
                            eng_scl = 1'b0;
                            fin     = 1'b1;
                        end
                    endcase
                end
                i2cmbe_pkg::CMD_READ: begin
                    case (eng_step)
                        6'd0: begin
                            free_sda();
                            eng_scl   = 1'b0;
                            eng_shift = 8'h00;
                            eng_hold  = i2cmbe_pkg::BIT_COUNT;
                        end
                        6'd1: begin
                            eng_shift = eng_shift << 1;
                            eng_scl   = 1'b1;
                        end
                        6'd2: begin
                            eng_shift = eng_shift | {7'd0, sda};
                            eng_scl   = 1'b0;
                            eng_hold  = eng_hold - 8'd1;
                            eng_step  = (eng_hold != 8'd0) ? 6'd1 : 6'd3;
                            adv       = 1'b0;
                        end
                        6'd3: drive_sda(!eng_ack_sel);
                        6'd4: eng_scl = 1'b1;
                        default: begin
                            eng_scl = 1'b0;
                            eng_rx  = eng_shift;
                            fin     = 1'b1;
                        end
                    endcase
                end
                default: fin = 1'b1;
            endcase
            if (fin) begin
                eng_busy = 1'b0;
                eng_step = '0;
            end else if (adv) begin
                eng_step = eng_step + 6'd1;
            end
        end
        r.scl     = eng_scl;
        r.sda     = eng_sda;
        r.sda_rel = eng_free;
        r.done    = fin;
        r.rx      = eng_rx;
        r.ack     = eng_ack;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    task automatic send_tick(input bit cv, input i2cmbe_pkg::t_cmd req, input logic [7:0] tx,
                             input bit sack, input bit sda, input bit has_exp,
                             input t_pins exp);
        t_pins p;
        while (send_gaps && $urandom_range(99) < 28) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        cmd_valid <= cv;
        req_type  <= req;
        tx_byte   <= tx;
        send_ack  <= sack;
        sda_in    <= sda;
        do @(posedge clk); while (in_stall);
        p = bus_tick(cv, req, tx, sack, sda);
        pins_due.push_back(has_exp ? exp : p);
        if (p.busy) engine_ticks++;
    endtask

    // first tick carries the command, the rest advance it until done
    task automatic run_cmd(input bit cv, input i2cmbe_pkg::t_cmd req, input logic [7:0] tx,
                           input bit sack, input logic [7:0] sda_pat, input bit noise,
                           input bit has_exp, input t_pins exp);
        int k;
        k = 0;
        send_tick(cv, req, tx, sack, sda_pat[0], has_exp, exp);
        while (eng_busy) begin
            k++;
            send_tick(noise && ($urandom_range(3) == 0),
                      i2cmbe_pkg::t_cmd'($urandom_range(7)),
                      8'($urandom), 1'($urandom), sda_pat[3'(k)], 1'b0, NO_PINS);
        end
    endtask

    task automatic rand_cmd(input bit cv, input i2cmbe_pkg::t_cmd req);
        run_cmd(cv, req, 8'($urandom), 1'($urandom), 8'($urandom),
                $urandom_range(9) == 0, 1'b0, NO_PINS);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pins_due.size() != 0) @(posedge clk);
    endtask

    task automatic set_hold(input logic [7:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        hold_ticks  = v;
    endtask

    task automatic run_traffic(input int quota);
        int               goal;
        int               r;
        bit               rd;
        i2cmbe_pkg::t_cmd req;
        goal = engine_ticks + quota;
        while (engine_ticks < goal) begin
            r = $urandom_range(99);
            if (r < 75) begin
                rand_cmd(1'b1, i2cmbe_pkg::CMD_START);
                rand_cmd(1'b1, i2cmbe_pkg::CMD_WRITE);
                rd = 1'($urandom);
                repeat ($urandom_range(3)) begin
                    rand_cmd(1'b1, rd ? i2cmbe_pkg::CMD_READ : i2cmbe_pkg::CMD_WRITE);
                end
                if ($urandom_range(3) == 0) begin
                    rand_cmd(1'b1, i2cmbe_pkg::CMD_START);
                    rand_cmd(1'b1, i2cmbe_pkg::CMD_READ);
                end
                rand_cmd(1'b1, i2cmbe_pkg::CMD_STOP);
            end else if (r < 85) begin
                repeat ($urandom_range(1, 4)) begin
                    rand_cmd(1'b0, i2cmbe_pkg::t_cmd'($urandom_range(7)));
                end
            end else if (r < 92) begin
                rand_cmd(1'b1, i2cmbe_pkg::t_cmd'($urandom_range(REQ_RSVD_7, REQ_RSVD_5)));
            end else begin
                req = i2cmbe_pkg::t_cmd'($urandom_range(i2cmbe_pkg::CMD_BUSRESET));
                if (req == i2cmbe_pkg::CMD_BUSRESET && hold_span() > 8'd32) begin
                    req = i2cmbe_pkg::CMD_STOP;
                end
                rand_cmd(1'b1, req);
            end
        end
    endtask

    always @(posedge clk) begin
        out_stall <= stall_gaps && ($urandom_range(99) < 28);
    end

    always @(posedge clk) begin : result_check
        t_pins want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                result_count++;
                if (pins_due.size() == 0) begin
                    $error("result transaction with no pending prediction");
                    error_count++;
                end else begin
                    want = pins_due.pop_front();
                    check_field("scl_out", 8'(want.scl), 8'(scl_out));
                    check_field("sda_out", 8'(want.sda), 8'(sda_out));
                    check_field("sda_released", 8'(want.sda_rel), 8'(sda_released));
                    check_field("busy_res", 8'(want.busy), 8'(busy_res));
                    check_field("done_res", 8'(want.done), 8'(done_res));
                    check_field("rx_byte", want.rx, rx_byte);
                    check_field("ack_ok", 8'(want.ack), 8'(ack_ok));
                end
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall)) quiet = 0;
            else quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] hold_plan [PHASES];
        int         ph;
        hold_ticks  = i2cmbe_pkg::HOLD_RESET;
        eng_cmd     = i2cmbe_pkg::CMD_START;
        eng_busy    = 1'b0;
        eng_step    = '0;
        eng_hold    = 8'h00;
        eng_shift   = 8'h00;
        eng_scl     = 1'b1;
        eng_sda     = 1'b1;
        eng_free    = 1'b0;
        eng_ack     = 1'b0;
        eng_ack_sel = 1'b0;
        eng_rx      = 8'h00;
        hold_plan   = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(3, 32)), 8'd2,
                        8'($urandom_range(3, 32))};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            run_cmd(dir_rows[i].cv, dir_rows[i].req, dir_rows[i].tx, dir_rows[i].sack,
                    dir_rows[i].sda_pat, dir_rows[i].noise, dir_rows[i].has_exp,
                    dir_rows[i].exp);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            set_hold(hold_plan[ph]);
            send_gaps  = (ph != 1);
            stall_gaps = (ph != 1);
            rand_cmd(1'b1, i2cmbe_pkg::CMD_BUSRESET);
            run_traffic(RAND_TICKS / PHASES);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d commands in %0d engine ticks; %0d result transactions checked.",
                 cmd_count, engine_ticks, result_count);
        $display("Bus reset at hold 200, 0, 1, 2, 255 and random; ack/nack, busy, unknown codes.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
